/* src/rhc_pkg.sv */
// ----------------------------------------------------------------------------
// rhc_pkg
// shared widths, codes, item types and helpers of the rgb / hls color converter
// ----------------------------------------------------------------------------
`default_nettype none

package rhc_pkg;

  localparam int ChW        = 13;     // channel width, q.12
  localparam int HueW       = 15;     // hue width, degrees times 64
  localparam int One        = 4096;   // channel value of 1.0
  localparam int Hue60      = 3840;   // 60 degrees
  localparam int Hue120     = 7680;
  localparam int Hue180     = 11520;
  localparam int Hue240     = 15360;
  localparam int HueFull    = 23040;  // full turn
  localparam int QW         = 13;     // quotient bits, one divider stage each
  localparam int NW         = 25;     // dividend width
  localparam int RecipMul   = 34953;  // ceil(2^19 / 15)
  localparam int RecipShift = 19;
  localparam int PipeLatency = QW + 7;

  // operation codes
  localparam logic [2:0] FnRgbToHls = 3'd0;
  localparam logic [2:0] FnHlsToRgb = 3'd1;
  localparam logic [2:0] FnSetL     = 3'd2;
  localparam logic [2:0] FnSetS     = 3'd3;
  localparam logic [2:0] FnSetH     = 3'd4;

  // ramp segment codes
  localparam logic [1:0] RsRamp = 2'd0;
  localparam logic [1:0] RsHigh = 2'd1;
  localparam logic [1:0] RsLow  = 2'd2;

  // side data that rides along the divider
  typedef struct packed {
    logic [2:0]      func;
    logic [ChW-1:0]  alpha;
    logic [HueW-1:0] nv;     // replacement value, already saturated or wrapped
    logic [HueW-1:0] ha;     // direct hls input for hls to rgb
    logic [ChW-1:0]  lb;
    logic [ChW-1:0]  sc;
    logic            gray;
    logic [ChW-1:0]  hi;
    logic [ChW:0]    sum;
    logic            hneg;
    logic [1:0]      hsec;
  } tag_t;

  typedef struct packed {
    logic [NW-1:0]  n_s;
    logic [ChW-1:0] d_s;
    logic [NW-1:0]  n_h;
    logic [ChW-1:0] d_h;
    tag_t           tag;
  } div_in_t;

  typedef struct packed {
    logic [NW-1:0]  rem_s;
    logic [ChW-1:0] d_s;
    logic [QW-1:0]  q_s;
    logic [NW-1:0]  rem_h;
    logic [ChW-1:0] d_h;
    logic [QW-1:0]  q_h;
    tag_t           tag;
  } div_stage_t;

  typedef struct packed {
    logic [QW-1:0] q_s;
    logic [QW-1:0] q_h;
    tag_t          tag;
  } div_out_t;

  typedef struct packed {
    logic [2:0]      func;
    logic [ChW-1:0]  alpha;
    logic [HueW-1:0] h;
    logic [ChW-1:0]  l;
    logic [ChW-1:0]  s;
  } hls_t;

  function automatic logic [ChW-1:0] sat_one(input logic [HueW-1:0] v);
    if (v > HueW'(One)) begin
      return ChW'(One);
    end
    return v[ChW-1:0];
  endfunction

  function automatic logic [HueW-1:0] wrap_hue(input logic [HueW-1:0] v);
    if (v >= HueW'(HueFull)) begin
      return v - HueW'(HueFull);
    end
    return v;
  endfunction

endpackage

`default_nettype wire

/* src/rgb_hls_color_convert.sv */
// ----------------------------------------------------------------------------
// rgb_hls_color_convert
// rgb to hls, hls to rgb and rgb with lightness, saturation or hue replaced
// ----------------------------------------------------------------------------
// Usage:
//   An item is taken at a rising edge with start high and busy low. busy is
//   always low, so a new item can be given in every cycle.
//   func_i picks the operation; comp_a_i/b/c carry rgb or hls, new_value_i
//   the replacement value, alpha_in_i passes through saturated to one.
//   The result of an item shows on out_a_o, out_b_o, out_c_o and alpha_out_o
//   for one cycle with done_o high, in the order items came in. One item per
//   cycle is sustained. The pipeline is made of the saturation and hue
//   dividers, one quotient bit per stage over 13 stages, plus the input stage,
//   the hls assembly stage and five stages of the hue ramp (product, segment,
//   ramp multiply, reciprocal multiply, output select).
//   The receiver cannot hold results off; none is needed, the pipeline never
//   stops. Reset clears all valid bits, so no result appears until an item
//   is taken after reset.
// ----------------------------------------------------------------------------
`default_nettype none

module rgb_hls_color_convert (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        start,
  output logic             busy,
  input  wire logic [2:0]  func_i,
  input  wire logic [14:0] comp_a_i,
  input  wire logic [12:0] comp_b_i,
  input  wire logic [12:0] comp_c_i,
  input  wire logic [12:0] alpha_in_i,
  input  wire logic [14:0] new_value_i,
  output logic             done_o,
  output logic [14:0]      out_a_o,
  output logic [12:0]      out_b_o,
  output logic [12:0]      out_c_o,
  output logic [12:0]      alpha_out_o
);

  localparam int ChW  = rhc_pkg::ChW;
  localparam int HueW = rhc_pkg::HueW;

  assign busy = 1'b0;

  // input stage: saturate channels, wrap hues
  logic            v0_q;
  logic [2:0]      func0_q;
  logic [HueW-1:0] a0_q;
  logic [ChW-1:0]  b0_q;
  logic [ChW-1:0]  c0_q;
  logic [ChW-1:0]  al0_q;
  logic [HueW-1:0] nv0_q;

  always_ff @(posedge clk_i) begin
    func0_q <= func_i;
    a0_q    <= (func_i == rhc_pkg::FnHlsToRgb) ? rhc_pkg::wrap_hue(comp_a_i) :
               HueW'(rhc_pkg::sat_one(comp_a_i));
    b0_q    <= rhc_pkg::sat_one(HueW'(comp_b_i));
    c0_q    <= rhc_pkg::sat_one(HueW'(comp_c_i));
    al0_q   <= rhc_pkg::sat_one(HueW'(alpha_in_i));
    nv0_q   <= (func_i == rhc_pkg::FnSetH) ? rhc_pkg::wrap_hue(new_value_i) :
               HueW'(rhc_pkg::sat_one(new_value_i));
  end

  // max / min, delta, sum and the two dividends
  logic [ChW-1:0]        r, g, b, hi, lo, delta, mag;
  logic [ChW:0]          sum;
  logic signed [ChW:0]   diff;
  rhc_pkg::div_in_t      div_in;

  always_comb begin
    r  = a0_q[ChW-1:0];
    g  = b0_q;
    b  = c0_q;
    hi = r;
    lo = r;
    if (g > hi) hi = g;
    if (b > hi) hi = b;
    if (g < lo) lo = g;
    if (b < lo) lo = b;
    delta = hi - lo;
    sum   = {1'b0, hi} + {1'b0, lo};

    div_in = '0;
    div_in.d_s = (sum < (ChW+1)'(rhc_pkg::One)) ? sum[ChW-1:0] :
                 ChW'((ChW+1)'(2 * rhc_pkg::One) - sum);
    div_in.n_s = rhc_pkg::NW'({delta, 12'b0}) + rhc_pkg::NW'(div_in.d_s >> 1);

    priority if (hi == r) begin
      diff = $signed({1'b0, g}) - $signed({1'b0, b});
      div_in.tag.hsec = 2'd0;
    end else if (hi == g) begin
      diff = $signed({1'b0, b}) - $signed({1'b0, r});
      div_in.tag.hsec = 2'd1;
    end else begin
      diff = $signed({1'b0, r}) - $signed({1'b0, g});
      div_in.tag.hsec = 2'd2;
    end
    mag        = (diff < 0) ? ChW'(-diff) : diff[ChW-1:0];
    div_in.d_h = delta;
    div_in.n_h = rhc_pkg::NW'(mag) * rhc_pkg::NW'(rhc_pkg::Hue60) +
                 rhc_pkg::NW'(delta >> 1);

    div_in.tag.func  = func0_q;
    div_in.tag.alpha = al0_q;
    div_in.tag.nv    = nv0_q;
    div_in.tag.ha    = a0_q;
    div_in.tag.lb    = b0_q;
    div_in.tag.sc    = c0_q;
    div_in.tag.gray  = (hi == lo);
    div_in.tag.hi    = hi;
    div_in.tag.sum   = sum;
    div_in.tag.hneg  = (diff < 0);
  end

  logic              div_vld;
  rhc_pkg::div_out_t div_out;

  rhc_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (v0_q),
    .in_i    (div_in),
    .valid_o (div_vld),
    .out_o   (div_out)
  );

  // assemble hls and apply replacement
  logic                   hls_vld_q;
  rhc_pkg::hls_t          hls_q, hls_d;
  logic signed [HueW+1:0] hraw;
  logic [ChW:0]           lsum;

  always_comb begin
    hraw = $signed((HueW+2)'(div_out.tag.hsec) * (HueW+2)'(rhc_pkg::Hue120));
    if (div_out.tag.hneg) begin
      hraw = hraw - $signed({4'b0, div_out.q_h});
    end else begin
      hraw = hraw + $signed({4'b0, div_out.q_h});
    end
    if (hraw < 0) begin
      hraw = hraw + (HueW+2)'(rhc_pkg::HueFull);
    end else if (hraw >= (HueW+2)'(rhc_pkg::HueFull)) begin
      hraw = hraw - (HueW+2)'(rhc_pkg::HueFull);
    end
    lsum = div_out.tag.sum + (ChW+1)'(1);

    hls_d.func  = div_out.tag.func;
    hls_d.alpha = div_out.tag.alpha;
    if (div_out.tag.gray) begin
      hls_d.h = '0;
      hls_d.l = div_out.tag.hi;
      hls_d.s = '0;
    end else begin
      hls_d.h = hraw[HueW-1:0];
      hls_d.l = lsum[ChW:1];
      hls_d.s = div_out.q_s;
    end
    unique case (div_out.tag.func)
      rhc_pkg::FnHlsToRgb: begin
        hls_d.h = div_out.tag.ha;
        hls_d.l = div_out.tag.lb;
        hls_d.s = div_out.tag.sc;
      end
      rhc_pkg::FnSetL: hls_d.l = div_out.tag.nv[ChW-1:0];
      rhc_pkg::FnSetS: hls_d.s = div_out.tag.nv[ChW-1:0];
      rhc_pkg::FnSetH: hls_d.h = div_out.tag.nv;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    hls_q <= hls_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q      <= 1'b0;
      hls_vld_q <= 1'b0;
    end else begin
      v0_q      <= start && !busy;
      hls_vld_q <= div_vld;
    end
  end

  rhc_ramp u_ramp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .valid_i     (hls_vld_q),
    .hls_i       (hls_q),
    .done_o      (done_o),
    .out_a_o     (out_a_o),
    .out_b_o     (out_b_o),
    .out_c_o     (out_c_o),
    .alpha_out_o (alpha_out_o)
  );

`ifndef SYNTH
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |-> ##(rhc_pkg::PipeLatency) done_o)
    else $error("item result missing at fixed latency");

  a_no_extra: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(start && !busy, rhc_pkg::PipeLatency))
    else $error("result without a matching item");

  a_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> (out_b_o <= 13'(rhc_pkg::One) && out_c_o <= 13'(rhc_pkg::One) &&
                alpha_out_o <= 13'(rhc_pkg::One)))
    else $error("channel result above one");

  a_hue: assert property (@(posedge clk_i) disable iff (!rst_ni)
    hls_vld_q |-> hls_q.h < 15'(rhc_pkg::HueFull))
    else $error("hue not wrapped");
`endif

endmodule

`default_nettype wire

/* src/rhc_div.sv */
// ----------------------------------------------------------------------------
// rhc_div
// two-lane pipelined restoring divider, one quotient bit per stage
// ----------------------------------------------------------------------------
`default_nettype none

module rhc_div (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             valid_i,
  input  wire rhc_pkg::div_in_t in_i,
  output logic                  valid_o,
  output rhc_pkg::div_out_t     out_o
);

  rhc_pkg::div_stage_t st_q [rhc_pkg::QW];
  logic [rhc_pkg::QW-1:0] vld_q;

  for (genvar k = 0; k < rhc_pkg::QW; k++) begin : g_stage
    rhc_pkg::div_stage_t src;
    rhc_pkg::div_stage_t st_d;
    logic [rhc_pkg::NW:0] sh_s;
    logic [rhc_pkg::NW:0] sh_h;

    if (k == 0) begin : g_first
      always_comb begin
        src       = '0;
        src.rem_s = in_i.n_s;
        src.d_s   = in_i.d_s;
        src.rem_h = in_i.n_h;
        src.d_h   = in_i.d_h;
        src.tag   = in_i.tag;
      end
    end else begin : g_next
      assign src = st_q[k-1];
    end

    always_comb begin
      st_d = src;
      sh_s = (rhc_pkg::NW+1)'(src.d_s) << (rhc_pkg::QW-1-k);
      sh_h = (rhc_pkg::NW+1)'(src.d_h) << (rhc_pkg::QW-1-k);
      if ({1'b0, src.rem_s} >= sh_s) begin
        st_d.rem_s = src.rem_s - sh_s[rhc_pkg::NW-1:0];
        st_d.q_s[rhc_pkg::QW-1-k] = 1'b1;
      end
      if ({1'b0, src.rem_h} >= sh_h) begin
        st_d.rem_h = src.rem_h - sh_h[rhc_pkg::NW-1:0];
        st_d.q_h[rhc_pkg::QW-1-k] = 1'b1;
      end
    end

    always_ff @(posedge clk_i) begin
      st_q[k] <= st_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[rhc_pkg::QW-2:0], valid_i};
    end
  end

  assign valid_o   = vld_q[rhc_pkg::QW-1];
  assign out_o.q_s = st_q[rhc_pkg::QW-1].q_s;
  assign out_o.q_h = st_q[rhc_pkg::QW-1].q_h;
  assign out_o.tag = st_q[rhc_pkg::QW-1].tag;

endmodule

`default_nettype wire

/* src/rhc_ramp.sv */
// ----------------------------------------------------------------------------
// rhc_ramp
// hls to rgb back end: lightness product, piecewise hue ramp, output select
// ----------------------------------------------------------------------------
`default_nettype none

module rhc_ramp (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          valid_i,
  input  wire rhc_pkg::hls_t hls_i,
  output logic               done_o,
  output logic [14:0]        out_a_o,
  output logic [12:0]        out_b_o,
  output logic [12:0]        out_c_o,
  output logic [12:0]        alpha_out_o
);

  localparam int ChW = rhc_pkg::ChW;

  typedef struct packed {
    logic [ChW-1:0]  v1;
    logic [ChW-1:0]  v2;
    logic [2:0][1:0] sel;
  } rmp_t;

  // stage p: l * s product
  logic            vp_q;
  rhc_pkg::hls_t   hp_q;
  logic [ChW-1:0]  p_q;
  logic [25:0]     prod_ls;

  assign prod_ls = 26'(hls_i.l) * 26'(hls_i.s) + 26'd2048;

  always_ff @(posedge clk_i) begin
    hp_q <= hls_i;
    p_q  <= prod_ls[ChW+11:12];
  end

  // stage v: v1, v2 and ramp segment per channel
  logic            vv_q;
  rhc_pkg::hls_t   hv_q;
  rmp_t            rv_q;
  rmp_t            rv_d;
  logic [ChW-1:0]  dif_q;
  logic [2:0][11:0] f_q;
  logic [2:0][11:0] f_d;
  logic [ChW:0]    v2w;
  logic signed [ChW+1:0] v1w;
  logic [2:0][14:0] hc;

  always_comb begin
    if ({hp_q.l, 1'b0} < (ChW+1)'(rhc_pkg::One)) begin
      v2w = {1'b0, hp_q.l} + {1'b0, p_q};
    end else begin
      v2w = {1'b0, hp_q.l} + {1'b0, hp_q.s} - {1'b0, p_q};
    end
    v1w = $signed({1'b0, hp_q.l, 1'b0}) - $signed({1'b0, v2w});
    rv_d.v2 = v2w[ChW-1:0];
    rv_d.v1 = (v1w < 0) ? '0 : v1w[ChW-1:0];

    // red is hue + 120, blue is hue - 120, both wrapped
    hc[0] = (hp_q.h >= 15'(rhc_pkg::HueFull - rhc_pkg::Hue120)) ?
            hp_q.h - 15'(rhc_pkg::HueFull - rhc_pkg::Hue120) :
            hp_q.h + 15'(rhc_pkg::Hue120);
    hc[1] = hp_q.h;
    hc[2] = (hp_q.h < 15'(rhc_pkg::Hue120)) ?
            hp_q.h + 15'(rhc_pkg::Hue240) : hp_q.h - 15'(rhc_pkg::Hue120);

    for (int i = 0; i < 3; i++) begin
      f_d[i] = '0;
      if (hc[i] < 15'(rhc_pkg::Hue60)) begin
        rv_d.sel[i] = rhc_pkg::RsRamp;
        f_d[i]      = hc[i][11:0];
      end else if (hc[i] < 15'(rhc_pkg::Hue180)) begin
        rv_d.sel[i] = rhc_pkg::RsHigh;
      end else if (hc[i] < 15'(rhc_pkg::Hue240)) begin
        rv_d.sel[i] = rhc_pkg::RsRamp;
        f_d[i]      = 12'(15'(rhc_pkg::Hue240) - hc[i]);
      end else begin
        rv_d.sel[i] = rhc_pkg::RsLow;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    hv_q  <= hp_q;
    rv_q  <= rv_d;
    f_q   <= f_d;
    dif_q <= rv_d.v2 - rv_d.v1;
  end

  // stage m: ramp products with half of 60 degrees for rounding
  logic            vm_q;
  rhc_pkg::hls_t   hm_q;
  rmp_t            rm_q;
  logic [2:0][24:0] x_q;

  always_ff @(posedge clk_i) begin
    hm_q <= hv_q;
    rm_q <= rv_q;
    for (int i = 0; i < 3; i++) begin
      x_q[i] <= 25'(dif_q) * 25'(f_q[i]) + 25'(rhc_pkg::Hue60 / 2);
    end
  end

  // stage r: divide by 3840 as a shift by 8 and a reciprocal of 15
  logic            vr_q;
  rhc_pkg::hls_t   hr_q;
  rmp_t            rr_q;
  logic [2:0][31:0] y_q;

  always_ff @(posedge clk_i) begin
    hr_q <= hm_q;
    rr_q <= rm_q;
    for (int i = 0; i < 3; i++) begin
      y_q[i] <= 32'(x_q[i][23:8]) * 32'(rhc_pkg::RecipMul);
    end
  end

  // stage o: select result
  logic            done_q;
  logic [14:0]     oa_q, oa_d;
  logic [12:0]     ob_q, ob_d;
  logic [12:0]     oc_q, oc_d;
  logic [12:0]     al_q;
  logic [2:0][ChW-1:0] ch;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      unique case (rr_q.sel[i])
        rhc_pkg::RsRamp: ch[i] = rr_q.v1 + y_q[i][rhc_pkg::RecipShift+ChW-1:rhc_pkg::RecipShift];
        rhc_pkg::RsHigh: ch[i] = rr_q.v2;
        default:         ch[i] = rr_q.v1;
      endcase
      if (hr_q.s == '0) begin
        ch[i] = hr_q.l;
      end
    end
    unique case (hr_q.func)
      rhc_pkg::FnRgbToHls: begin
        oa_d = hr_q.h;
        ob_d = hr_q.l;
        oc_d = hr_q.s;
      end
      rhc_pkg::FnHlsToRgb, rhc_pkg::FnSetL, rhc_pkg::FnSetS, rhc_pkg::FnSetH: begin
        oa_d = 15'(ch[0]);
        ob_d = ch[1];
        oc_d = ch[2];
      end
      default: begin
        oa_d = '0;
        ob_d = '0;
        oc_d = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    oa_q <= oa_d;
    ob_q <= ob_d;
    oc_q <= oc_d;
    al_q <= hr_q.alpha;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vp_q   <= 1'b0;
      vv_q   <= 1'b0;
      vm_q   <= 1'b0;
      vr_q   <= 1'b0;
      done_q <= 1'b0;
    end else begin
      vp_q   <= valid_i;
      vv_q   <= vp_q;
      vm_q   <= vv_q;
      vr_q   <= vm_q;
      done_q <= vr_q;
    end
  end

  assign done_o      = done_q;
  assign out_a_o     = oa_q;
  assign out_b_o     = ob_q;
  assign out_c_o     = oc_q;
  assign alpha_out_o = al_q;

endmodule

`default_nettype wire
